### hdl/allocation_tracking_table_defines.svh
// Assertion macros for the allocation tracking table.
// Used by allocation_tracking_table.sv; expects clk and rst_n in scope.
`ifndef ALLOCATION_TRACKING_TABLE_DEFINES_SVH
`define ALLOCATION_TRACKING_TABLE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ATT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ATT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/att_pkg.sv
// Types and codes for the allocation tracking table.
// No dependencies; imported by allocation_tracking_table.
`default_nettype none

package att_pkg;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NULL      = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_UNTRACKED = 2'd3;

  typedef struct packed {
    logic        op;
    logic [31:0] address;
    logic [31:0] block_size;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] assigned_id;
    logic [6:0]  active_count;
    logic [31:0] live_size_sum;
    logic [6:0]  peak_count;
    logic [31:0] peak_size_sum;
    logic [31:0] lifetime_allocs;
    logic [47:0] alloc_size_sum;
    logic [31:0] free_total;
    logic [31:0] invalid_free_total;
  } out_word_t;

  // one table row
  typedef struct packed {
    logic        valid;
    logic [31:0] address;
    logic [31:0] size;
  } entry_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_A_BYTES,
    S_A_TOTAL,
    S_A_COUNT,
    S_A_ID,
    S_F_BYTES,
    S_F_COUNT,
    S_BAD,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

### hdl/allocation_tracking_table.sv
// Allocation tracking table: top level, table memory and sequencer.
// Depends on att_pkg and allocation_tracking_table_defines.svh.
`default_nettype none

// Channel   Ports                      Handshake
// input     in_word                    taken when start && !busy
// result    out_word                   out_valid strobe, one cycle, no stall
//
// A null address goes straight to the result. Otherwise the table is scanned
// through the single registered memory read port, one row a cycle, and the
// shared adder then takes bytes, total, count and id for an alloc, bytes and
// count for a free, or the invalid-free count for an untracked free.
// After reset a clearing pass over every row runs with busy high.
// busy stays high from accept until the strobe cycle; the result cannot be
// held off, so it is shown for exactly one cycle.

`include "allocation_tracking_table_defines.svh"

module allocation_tracking_table
  import att_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  output out_word_t      out_word
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IW:0]   DEPTH_W = (IW + 1)'(TABLE_DEPTH);
  localparam logic [IW-1:0] LAST    = IW'(TABLE_DEPTH - 1);

  // table memory: one write port, one registered read port
  entry_t          mem [TABLE_DEPTH];
  entry_t          rd_data_r;
  logic            rd_en;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  entry_t          wr_data;

  state_t          state_r, state_nxt;
  in_word_t        in_r, in_nxt;
  logic [IW-1:0]   scan_idx_r, scan_idx_nxt;
  logic            chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]   chk_idx_r, chk_idx_nxt;
  logic [IW-1:0]   slot_r, slot_nxt;
  logic [31:0]     size_r, size_nxt;
  logic [1:0]      status_r, status_nxt;
  logic [31:0]     id_r, id_nxt;

  logic [31:0]     next_id_r, next_id_nxt;
  logic [CW-1:0]   live_count_r, live_count_nxt;
  logic [31:0]     live_bytes_r, live_bytes_nxt;
  logic [CW-1:0]   max_count_r, max_count_nxt;
  logic [31:0]     max_bytes_r, max_bytes_nxt;
  logic [31:0]     alloc_cnt_r, alloc_cnt_nxt;
  logic [47:0]     alloc_bytes_r, alloc_bytes_nxt;
  logic [31:0]     free_cnt_r, free_cnt_nxt;
  logic [31:0]     bad_cnt_r, bad_cnt_nxt;

  // shared adder / subtractor
  logic [47:0]     add_a, add_b;
  logic            add_sub;
  logic [48:0]     add_sum;

  logic            hit;

  assign add_sum = {1'b0, add_a} + ({1'b0, add_b} ^ {49{add_sub}}) + 49'(add_sub);

  // row under check matches the request
  always_comb begin
    if (in_r.op == OP_ALLOC) begin
      hit = !rd_data_r.valid;
    end else begin
      hit = rd_data_r.valid && (rd_data_r.address == in_r.address);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[scan_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      scan_idx_r    <= '0;
      chk_vld_r     <= 1'b0;
      next_id_r     <= 32'd1;
      live_count_r  <= '0;
      live_bytes_r  <= '0;
      max_count_r   <= '0;
      max_bytes_r   <= '0;
      alloc_cnt_r   <= '0;
      alloc_bytes_r <= '0;
      free_cnt_r    <= '0;
      bad_cnt_r     <= '0;
    end else begin
      state_r       <= state_nxt;
      scan_idx_r    <= scan_idx_nxt;
      chk_vld_r     <= chk_vld_nxt;
      next_id_r     <= next_id_nxt;
      live_count_r  <= live_count_nxt;
      live_bytes_r  <= live_bytes_nxt;
      max_count_r   <= max_count_nxt;
      max_bytes_r   <= max_bytes_nxt;
      alloc_cnt_r   <= alloc_cnt_nxt;
      alloc_bytes_r <= alloc_bytes_nxt;
      free_cnt_r    <= free_cnt_nxt;
      bad_cnt_r     <= bad_cnt_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    in_r      <= in_nxt;
    chk_idx_r <= chk_idx_nxt;
    slot_r    <= slot_nxt;
    size_r    <= size_nxt;
    status_r  <= status_nxt;
    id_r      <= id_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    in_nxt          = in_r;
    scan_idx_nxt    = scan_idx_r;
    chk_vld_nxt     = chk_vld_r;
    chk_idx_nxt     = chk_idx_r;
    slot_nxt        = slot_r;
    size_nxt        = size_r;
    status_nxt      = status_r;
    id_nxt          = id_r;
    next_id_nxt     = next_id_r;
    live_count_nxt  = live_count_r;
    live_bytes_nxt  = live_bytes_r;
    max_count_nxt   = max_count_r;
    max_bytes_nxt   = max_bytes_r;
    alloc_cnt_nxt   = alloc_cnt_r;
    alloc_bytes_nxt = alloc_bytes_r;
    free_cnt_nxt    = free_cnt_r;
    bad_cnt_nxt     = bad_cnt_r;
    add_a           = '0;
    add_b           = '0;
    add_sub         = 1'b0;
    rd_en           = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = slot_r;
    wr_data         = '{valid: 1'b0, address: in_r.address, size: in_r.block_size};

    unique case (state_r)
      // invalidate every row after reset
      S_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = scan_idx_r;
        scan_idx_nxt = scan_idx_r + IW'(1);
        if (scan_idx_r == LAST) begin
          scan_idx_nxt = '0;
          state_nxt    = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          in_nxt = in_word;
          id_nxt = '0;
          if (in_word.address == 32'd0) begin
            status_nxt = ST_NULL;
            state_nxt  = S_RESP;
          end else begin
            scan_idx_nxt = '0;
            chk_vld_nxt  = 1'b0;
            state_nxt    = S_SCAN;
          end
        end
      end

      // read row scan_idx while checking the row read last cycle
      S_SCAN: begin
        rd_en        = ({1'b0, scan_idx_r} < DEPTH_W);
        chk_vld_nxt  = 1'b1;
        chk_idx_nxt  = scan_idx_r;
        scan_idx_nxt = scan_idx_r + IW'(1);
        if (chk_vld_r) begin
          if (hit) begin
            slot_nxt   = chk_idx_r;
            size_nxt   = rd_data_r.size;
            status_nxt = ST_OK;
            if (in_r.op == OP_ALLOC) begin
              id_nxt    = next_id_r;
              state_nxt = S_A_BYTES;
            end else begin
              state_nxt = S_F_BYTES;
            end
          end else if (chk_idx_r == LAST) begin
            if (in_r.op == OP_ALLOC) begin
              status_nxt = ST_FULL;
              state_nxt  = S_RESP;
            end else begin
              status_nxt = ST_UNTRACKED;
              state_nxt  = S_BAD;
            end
          end
        end
      end

      S_A_BYTES: begin
        wr_en          = 1'b1;
        wr_data.valid  = 1'b1;
        add_a          = {16'd0, live_bytes_r};
        add_b          = {16'd0, in_r.block_size};
        live_bytes_nxt = add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];
        live_count_nxt = live_count_r + CW'(1);
        state_nxt      = S_A_TOTAL;
      end

      S_A_TOTAL: begin
        add_a           = alloc_bytes_r;
        add_b           = {16'd0, in_r.block_size};
        alloc_bytes_nxt = add_sum[48] ? 48'hFFFF_FFFF_FFFF : add_sum[47:0];
        state_nxt       = S_A_COUNT;
      end

      S_A_COUNT: begin
        add_a         = {16'd0, alloc_cnt_r};
        add_b         = 48'd1;
        alloc_cnt_nxt = add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];
        state_nxt     = S_A_ID;
      end

      // id advance plus peak tracking
      S_A_ID: begin
        add_a       = {16'd0, next_id_r};
        add_b       = 48'd1;
        next_id_nxt = add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];
        if (live_count_r > max_count_r) begin
          max_count_nxt = live_count_r;
        end
        if (live_bytes_r > max_bytes_r) begin
          max_bytes_nxt = live_bytes_r;
        end
        state_nxt = S_RESP;
      end

      // clear the row, clamp bytes at zero on underflow
      S_F_BYTES: begin
        wr_en          = 1'b1;
        add_a          = {16'd0, live_bytes_r};
        add_b          = {16'd0, size_r};
        add_sub        = 1'b1;
        live_bytes_nxt = add_sum[48] ? 32'd0 : add_sum[31:0];
        if (live_count_r != '0) begin
          live_count_nxt = live_count_r - CW'(1);
        end
        state_nxt = S_F_COUNT;
      end

      S_F_COUNT: begin
        add_a        = {16'd0, free_cnt_r};
        add_b        = 48'd1;
        free_cnt_nxt = add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];
        state_nxt    = S_RESP;
      end

      S_BAD: begin
        add_a       = {16'd0, bad_cnt_r};
        add_b       = 48'd1;
        bad_cnt_nxt = add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];
        state_nxt   = S_RESP;
      end

      S_RESP: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESP);

  always_comb begin
    out_word.status             = status_r;
    out_word.assigned_id        = id_r;
    out_word.active_count       = 7'(live_count_r);
    out_word.live_size_sum      = live_bytes_r;
    out_word.peak_count         = 7'(max_count_r);
    out_word.peak_size_sum      = max_bytes_r;
    out_word.lifetime_allocs    = alloc_cnt_r;
    out_word.alloc_size_sum     = alloc_bytes_r;
    out_word.free_total         = free_cnt_r;
    out_word.invalid_free_total = bad_cnt_r;
  end

  // checks
  `ATT_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe longer than one cycle")
  `ATT_ASSERT_IMPL(a_id_only_ok, out_valid && (out_word.assigned_id != 32'd0), out_word.status == ST_OK, "id given on failed event")
  `ATT_ASSERT_IMPL(a_count_bound, 1'b1, {1'b0, live_count_r} <= (CW + 1)'(TABLE_DEPTH), "live count above table depth")
  `ATT_ASSERT_IMPL(a_peak_bound, state_r == S_IDLE, (live_count_r <= max_count_r) && (live_bytes_r <= max_bytes_r || in_r.op == OP_FREE || in_r.address == 32'd0 || status_r != ST_OK), "live total above its peak")

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for allocation_tracking_table.
// Depends on att_pkg (word types, op and status codes) and the block's RTL.
// A behavioral copy of the table predicts every result word; results are checked in order.
`default_nettype none

module testbench;
  import att_pkg::*;

  localparam int TBL_DEPTH = 64;

  // Slowest correct run: about 860 events, each at most a table scan plus
  // an idle gap, with the pauses on top. Taken several times over.
  localparam int CYCLE_LIMIT = 1_000_000;

  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_valid;
  out_word_t out_word;

  int        error_count;
  int        cycle_count;

  // one predicted result word per accepted event, oldest first
  out_word_t pending_reports[$];
  out_word_t due_report;

  // shadow of the tracking table and its counters
  logic        tbl_valid [TBL_DEPTH];
  logic [31:0] tbl_addr  [TBL_DEPTH];
  logic [31:0] tbl_size  [TBL_DEPTH];
  logic [31:0] id_next;
  logic [6:0]  live_cnt;
  logic [31:0] live_bytes;
  logic [6:0]  max_cnt;
  logic [31:0] max_bytes;
  logic [31:0] alloc_cnt;
  logic [47:0] alloc_bytes;
  logic [31:0] freed_cnt;
  logic [31:0] bad_free_cnt;

  allocation_tracking_table #(
    .TABLE_DEPTH(TBL_DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  // 20-unit clock period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------

  // Applies one event to the shadow table and returns the result word the
  // block must report for it: counters as they stand after the event.
  function automatic out_word_t track_event(input in_word_t w);
    out_word_t   r;
    int          slot;
    int          i;
    logic [32:0] sum32;
    logic [48:0] sum48;
    slot          = -1;
    r             = '0;
    r.status      = ST_OK;
    r.assigned_id = '0;
    if (w.address == '0) begin
      // null address: ignored for both ops, counters untouched
      r.status = ST_NULL;
    end else if (w.op == OP_ALLOC) begin
      // lowest free slot wins
      for (i = TBL_DEPTH - 1; i >= 0; i--)
        if (!tbl_valid[i]) slot = i;
      if (slot < 0) begin
        r.status = ST_FULL;
      end else begin
        tbl_valid[slot] = 1'b1;
        tbl_addr[slot]  = w.address;
        tbl_size[slot]  = w.block_size;
        r.assigned_id   = id_next;
        if (id_next != MAX32) id_next = id_next + 32'd1;
        live_cnt    = live_cnt + 7'd1;
        sum32       = {1'b0, live_bytes} + w.block_size;
        live_bytes  = sum32[32] ? MAX32 : sum32[31:0];
        if (alloc_cnt != MAX32) alloc_cnt = alloc_cnt + 32'd1;
        sum48       = {1'b0, alloc_bytes} + w.block_size;
        alloc_bytes = sum48[48] ? MAX48 : sum48[47:0];
        if (live_cnt > max_cnt) max_cnt = live_cnt;
        if (live_bytes > max_bytes) max_bytes = live_bytes;
      end
    end else begin
      // lowest valid entry with a matching address wins
      for (i = TBL_DEPTH - 1; i >= 0; i--)
        if (tbl_valid[i] && tbl_addr[i] == w.address) slot = i;
      if (slot < 0) begin
        r.status = ST_UNTRACKED;
        if (bad_free_cnt != MAX32) bad_free_cnt = bad_free_cnt + 32'd1;
      end else begin
        tbl_valid[slot] = 1'b0;
        if (freed_cnt != MAX32) freed_cnt = freed_cnt + 32'd1;
        if (live_cnt != 0) live_cnt = live_cnt - 7'd1;
        // clamp at zero when live bytes had saturated
        live_bytes = (tbl_size[slot] <= live_bytes) ? live_bytes - tbl_size[slot] : '0;
      end
    end
    r.active_count       = live_cnt;
    r.live_size_sum      = live_bytes;
    r.peak_count         = max_cnt;
    r.peak_size_sum      = max_bytes;
    r.lifetime_allocs    = alloc_cnt;
    r.alloc_size_sum     = alloc_bytes;
    r.free_total         = freed_cnt;
    r.invalid_free_total = bad_free_cnt;
    return r;
  endfunction

  // Address of a randomly chosen live entry, 0 if the table is empty.
  function automatic logic [31:0] pick_live_address();
    int          first;
    int          k;
    logic [31:0] a;
    a     = '0;
    first = $urandom_range(TBL_DEPTH - 1);
    for (k = 0; k < TBL_DEPTH; k++)
      if (a == '0 && tbl_valid[(first + k) % TBL_DEPTH])
        a = tbl_addr[(first + k) % TBL_DEPTH];
    return a;
  endfunction

  // Mostly a small pool so that the same address is often live twice.
  function automatic logic [31:0] rand_address();
    int sel;
    sel = $urandom_range(99);
    if (sel < 45) return $urandom;
    if (sel < 90) return 32'h8000_0000 | ($urandom_range(1, 20) << 3);
    return $urandom_range(1, 8);
  endfunction

  function automatic logic [31:0] rand_size();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return $urandom_range(1, 32'h0001_0000);
    if (sel < 80) return '0;
    if (sel < 95) return $urandom;
    return MAX32 - $urandom_range(0, 3);
  endfunction

  // --------------------------------------------------------------------
  // Driving (inputs change on the falling edge)
  // --------------------------------------------------------------------

  // Presents one event word and holds it until the block takes it. start
  // stays high on return; the caller's next send or gap sets it at the
  // following falling edge.
  task automatic send_event(input logic op, input logic [31:0] addr,
                            input logic [31:0] size);
    in_word_t w;
    w.op         = op;
    w.address    = addr;
    w.block_size = size;
    @(negedge clk);
    start   = 1'b1;
    in_word = w;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pending_reports.push_back(track_event(w));
  endtask

  // Random idle stretch: mostly none or short, a few long. The input word
  // carries junk meanwhile, which the block must ignore.
  task automatic idle_gap();
    int sel;
    int len;
    sel = $urandom_range(99);
    if (sel < 55)      len = 0;
    else if (sel < 90) len = $urandom_range(1, 4);
    else               len = $urandom_range(8, 60);
    repeat (len) begin
      @(negedge clk);
      start              = 1'b0;
      in_word.op         = 1'($urandom_range(1));
      in_word.address    = $urandom;
      in_word.block_size = $urandom;
    end
  endtask

  // Sender holds off until every predicted word has come back.
  task automatic wait_all_reported();
    @(negedge clk);
    start = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic free_all_live();
    while (live_cnt != 0) begin
      send_event(OP_FREE, pick_live_address(), $urandom);
      idle_gap();
    end
  endtask

  // --------------------------------------------------------------------
  // Checking (outputs sampled on the rising edge)
  // --------------------------------------------------------------------

  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0) begin
      if (pending_reports.size() == 0) begin
        error_count++;
        $display("%0t: result word with none expected, actual %0h", $time, out_word);
      end else begin
        due_report = pending_reports.pop_front();
        check_field("status", 48'(due_report.status), 48'(out_word.status));
        check_field("assigned_id", 48'(due_report.assigned_id),
                    48'(out_word.assigned_id));
        check_field("active_count", 48'(due_report.active_count),
                    48'(out_word.active_count));
        check_field("live_size_sum", 48'(due_report.live_size_sum),
                    48'(out_word.live_size_sum));
        check_field("peak_count", 48'(due_report.peak_count),
                    48'(out_word.peak_count));
        check_field("peak_size_sum", 48'(due_report.peak_size_sum),
                    48'(out_word.peak_size_sum));
        check_field("lifetime_allocs", 48'(due_report.lifetime_allocs),
                    48'(out_word.lifetime_allocs));
        check_field("alloc_size_sum", due_report.alloc_size_sum,
                    out_word.alloc_size_sum);
        check_field("free_total", 48'(due_report.free_total),
                    48'(out_word.free_total));
        check_field("invalid_free_total", 48'(due_report.invalid_free_total),
                    48'(out_word.invalid_free_total));
      end
    end
  end

  // --------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------

  // Null address for both ops, on an empty table and with any size.
  task automatic test_null_events();
    send_event(OP_ALLOC, 32'h0, MAX32);
    send_event(OP_FREE,  32'h0, 32'h0);
    idle_gap();
    send_event(OP_ALLOC, 32'h0, 32'h0);
    send_event(OP_FREE,  32'h0, MAX32);
    idle_gap();
  endtask

  // Fill every slot, overflow, free one in the middle and check that the
  // next alloc lands in the hole, then empty the table again.
  task automatic test_table_full();
    int k;
    for (k = 0; k < TBL_DEPTH; k++) begin
      send_event(OP_ALLOC, $urandom | 32'h1, $urandom_range(1, 32'h0010_0000));
      idle_gap();
    end
    send_event(OP_ALLOC, $urandom | 32'h1, $urandom);
    send_event(OP_ALLOC, MAX32, MAX32);
    idle_gap();
    send_event(OP_FREE, tbl_addr[37], $urandom);
    send_event(OP_ALLOC, $urandom | 32'h1, $urandom_range(1, 4096));
    send_event(OP_ALLOC, $urandom | 32'h1, 32'h0);
    // null while full still reports null, not full
    send_event(OP_ALLOC, 32'h0, 32'h10);
    idle_gap();
    free_all_live();
    wait_all_reported();
  endtask

  // Field extremes, live byte saturation and the clamp on free, duplicate
  // addresses, double free and frees of untracked addresses.
  task automatic test_field_extremes();
    send_event(OP_FREE,  32'hDEAD_BEEF, MAX32);       // untracked, table empty
    send_event(OP_ALLOC, 32'h0000_0001, 32'h0);
    send_event(OP_ALLOC, MAX32,         MAX32);
    idle_gap();
    send_event(OP_ALLOC, 32'h8000_0000, MAX32);       // live bytes saturate here
    send_event(OP_ALLOC, 32'h5555_5555, 32'hAAAA_AAAA);
    send_event(OP_ALLOC, 32'h5555_5555, 32'h0000_0001);
    send_event(OP_FREE,  32'h0,         32'h1234);    // null while entries are live
    idle_gap();
    send_event(OP_FREE,  MAX32,         32'h0);       // drops live bytes to zero
    send_event(OP_FREE,  32'h8000_0000, 32'h0);       // size above live bytes: clamp
    send_event(OP_FREE,  32'h5555_5555, 32'h0);       // lower duplicate goes first
    send_event(OP_FREE,  32'h5555_5555, MAX32);
    send_event(OP_FREE,  32'h5555_5555, 32'h0);       // double free
    idle_gap();
    send_event(OP_FREE,  32'h0000_0001, 32'h0);
    send_event(OP_ALLOC, 32'hAAAA_AAAA, 32'h5555_5555);
    send_event(OP_FREE,  32'hAAAA_AAAA, 32'h0);
    send_event(OP_FREE,  32'h0000_0002, 32'h0);       // untracked
    wait_all_reported();
  endtask

  // Random traffic in four stretches with different alloc bias, so the
  // table wanders between empty and full. Mostly well-formed alloc/free
  // pairs; some nulls, stray frees and repeat frees as noise.
  task automatic test_random_traffic();
    int          seg;
    int          n;
    int          r;
    int          alloc_pct;
    logic [31:0] last_freed;
    logic [31:0] a;
    last_freed = '0;
    for (seg = 0; seg < 4; seg++) begin
      case (seg)
        0:       alloc_pct = 75;
        1:       alloc_pct = 35;
        2:       alloc_pct = 92;
        default: alloc_pct = 50;
      endcase
      for (n = 0; n < 175; n++) begin
        r = $urandom_range(99);
        if (r < 3) begin
          send_event(1'($urandom_range(1)), 32'h0, $urandom);
        end else if (r < 8) begin
          send_event(OP_FREE, rand_address(), $urandom);
        end else if (r < 11 && last_freed != '0) begin
          send_event(OP_FREE, last_freed, $urandom);
        end else if (live_cnt != 0 && $urandom_range(99) >= alloc_pct) begin
          a = pick_live_address();
          send_event(OP_FREE, a, $urandom);
          last_freed = a;
        end else begin
          send_event(OP_ALLOC, rand_address(), rand_size());
        end
        idle_gap();
        if ($urandom_range(99) == 0) wait_all_reported();
      end
      wait_all_reported();
    end
  endtask

  // --------------------------------------------------------------------
  // Run control
  // --------------------------------------------------------------------

  initial begin
    int i;
    clk         = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_word     = '0;
    error_count = 0;
    for (i = 0; i < TBL_DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_addr[i]  = '0;
      tbl_size[i]  = '0;
    end
    id_next      = 32'd1;
    live_cnt     = '0;
    live_bytes   = '0;
    max_cnt      = '0;
    max_bytes    = '0;
    alloc_cnt    = '0;
    alloc_bytes  = '0;
    freed_cnt    = '0;
    bad_free_cnt = '0;

    // synchronous reset, released at a falling edge; the clearing pass that
    // follows shows up as busy and is waited out by the first send
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_null_events();
    test_table_full();
    test_field_extremes();
    test_random_traffic();

    // every word is back; give a stray late word time to show up
    wait_all_reported();
    repeat (2 * TBL_DEPTH + 16) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d words outstanding",
             cycle_count, pending_reports.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
